/* rtl/core/prtc_pkg.sv */
`timescale 1ns / 1ps

package prtc_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int BASE_W    = COORD_W + 1;
	localparam int TRIG_W    = 18;
	localparam int PROD_W    = DIFF_W + TRIG_W;
	localparam int ROT_W     = PROD_W + 1 - 16;
	localparam int WORLD_W   = ROT_W + 1;
	localparam int CRD_W     = 34;
	localparam int ANGLE_W   = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd4;

	localparam logic signed [CRD_W-1:0]  CORDIC_GAIN = 34'sd652032874;
	localparam logic [32:0]              TWO_PI_Q30  = 33'd6746518852;
	localparam logic signed [TRIG_W-1:0] TRIG_ONE    = 18'sd65536;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic                     last;
	} vtx_t;

	typedef struct packed {
		logic valid;
		vtx_t vtx;
	} head_t;

	// arctangent of 2^-i in Q2.30
	function automatic logic signed [CRD_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [CRD_W-1:0] r;
		unique case (i)
			5'd0:    r = 34'sd843314857;
			5'd1:    r = 34'sd497837829;
			5'd2:    r = 34'sd263043837;
			5'd3:    r = 34'sd133525159;
			5'd4:    r = 34'sd67021687;
			5'd5:    r = 34'sd33543516;
			5'd6:    r = 34'sd16775851;
			5'd7:    r = 34'sd8388437;
			5'd8:    r = 34'sd4194283;
			5'd9:    r = 34'sd2097149;
			5'd10:   r = 34'sd1048576;
			default: r = 34'sd1 <<< (5'd30 - i);
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/polygon_rotate_translate_centroid.sv */
`timescale 1ns / 1ps

// Rigid 2-D transform of polygon vertices about a pivot, with a centroid on the last vertex.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 sets the angle
// (65536 = one turn), 1 and 2 the pivot, 3 and 4 the offset, all Q16.16. Write only while idle.
// An angle write starts the sine/cosine unit; in_ready stays low while its rotation and final steps run.
// Input: in_valid/in_ready with local_x, local_y and final_vertex, one vertex per item.
// Output: out_valid/out_ready with one result item per vertex: the saturated world vertex and,
// on the final vertex, the centroid of the polygon (truncated toward zero).
// An ordinary vertex passes the product stage, the rotation stage and the output register.
// Ordinary vertices stream at one per cycle through the multiplier pipeline unless it stalls.
// The final vertex also runs the centroid divider, one quotient bit a cycle, and the pipeline waits for it.
// Only the first MAX_VERTICES vertices of a polygon enter the centroid sums.
// When the receiver stalls, the result is held in the output register, the pipeline stops
// and a two-entry queue in the front end absorbs in-flight vertices before in_ready falls.
// Reset clears the sums, the vertex count, the configuration and the control state; cosine resets to one, sine to zero.

module polygon_rotate_translate_centroid import prtc_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [COORD_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] local_x,
	input  logic signed [COORD_W-1:0] local_y,
	input  logic                      final_vertex,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] world_x,
	output logic signed [COORD_W-1:0] world_y,
	output logic signed [COORD_W-1:0] centroid_x,
	output logic signed [COORD_W-1:0] centroid_y,
	output logic                      centroid_valid,
	output logic                      saturated
);

	logic signed [COORD_W-1:0] pivot_x_q, pivot_y_q, offset_x_q, offset_y_q;
	logic signed [BASE_W-1:0]  base_x_q, base_y_q;
	logic                      cfg_wr, crd_start, crd_busy, pop;
	logic signed [TRIG_W-1:0]  cos_value, sin_value;
	head_t                     head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign crd_start = cfg_wr && (cfg_index == CFG_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_x_q  <= '0;
			pivot_y_q  <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
			base_x_q   <= '0;
			base_y_q   <= '0;
		end else begin
			base_x_q <= {pivot_x_q[COORD_W-1], pivot_x_q} + {offset_x_q[COORD_W-1], offset_x_q};
			base_y_q <= {pivot_y_q[COORD_W-1], pivot_y_q} + {offset_y_q[COORD_W-1], offset_y_q};
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_PIVOT_X:  pivot_x_q  <= cfg_data;
					CFG_PIVOT_Y:  pivot_y_q  <= cfg_data;
					CFG_OFFSET_X: offset_x_q <= cfg_data;
					CFG_OFFSET_Y: offset_y_q <= cfg_data;
					default:      ;
				endcase
			end
		end
	end

	prtc_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (crd_start),
		.angle     (cfg_data[ANGLE_W-1:0]),
		.busy      (crd_busy),
		.cos_value (cos_value),
		.sin_value (sin_value)
	);

	prtc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.local_x      (local_x),
		.local_y      (local_y),
		.final_vertex (final_vertex),
		.pivot_x      (pivot_x_q),
		.pivot_y      (pivot_y_q),
		.hold         (crd_busy),
		.pop          (pop),
		.head         (head)
	);

	prtc_back #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.cos_value      (cos_value),
		.sin_value      (sin_value),
		.base_x         (base_x_q),
		.base_y         (base_y_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.world_x        (world_x),
		.world_y        (world_y),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.centroid_valid (centroid_valid),
		.saturated      (saturated)
	);

endmodule

/* rtl/core/prtc_cordic.sv */
`timescale 1ns / 1ps

module prtc_cordic import prtc_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ANGLE_W-1:0]       angle,
	output logic                     busy,
	output logic signed [TRIG_W-1:0] cos_value,
	output logic signed [TRIG_W-1:0] sin_value
);

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROT  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]              state_q;
	logic [STEP_W-1:0]       step_q;
	logic [1:0]              quad_q;
	logic signed [CRD_W-1:0] x_q, y_q, z_q;

	logic [46:0]             zprod;
	logic signed [CRD_W-1:0] z0, xs, ys, atan_i;
	logic signed [CRD_W-1:0] c_full, s_full, cos_raw, sin_raw;

	function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [CRD_W-1:0] v);
		logic signed [TRIG_W-1:0] r;
		if (v > 34'sd65536) begin
			r = TRIG_ONE;
		end else if (v < -34'sd65536) begin
			r = -TRIG_ONE;
		end else begin
			r = v[TRIG_W-1:0];
		end
		return r;
	endfunction

	assign zprod  = {33'd0, angle[13:0]} * {14'd0, TWO_PI_Q30};
	assign z0     = {3'b000, zprod[46:16]};
	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_i = atan_entry(5'(step_q));
	assign c_full = (x_q + 34'sd8192) >>> 14;
	assign s_full = (y_q + 34'sd8192) >>> 14;
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		unique case (quad_q)
			2'd0: begin cos_raw = c_full;  sin_raw = s_full;  end
			2'd1: begin cos_raw = -s_full; sin_raw = c_full;  end
			2'd2: begin cos_raw = -c_full; sin_raw = -s_full; end
			default: begin cos_raw = s_full;  sin_raw = -c_full; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cos_value <= TRIG_ONE;
			sin_value <= '0;
		end else if (start) begin
			state_q <= ST_ROT;
		end else begin
			unique case (state_q)
				ST_ROT: begin
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q   <= ST_IDLE;
					cos_value <= clamp_trig(cos_raw);
					sin_value <= clamp_trig(sin_raw);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= angle[15:14];
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= z0;
			step_q <= '0;
		end else if (state_q == ST_ROT) begin
			if (!z_q[CRD_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_i;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_i;
			end
			step_q <= step_q + 1'b1;
		end
	end

endmodule

/* rtl/core/prtc_front.sv */
`timescale 1ns / 1ps

module prtc_front import prtc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] local_x,
	input  logic signed [COORD_W-1:0] local_y,
	input  logic                      final_vertex,
	input  logic signed [COORD_W-1:0] pivot_x,
	input  logic signed [COORD_W-1:0] pivot_y,
	input  logic                      hold,
	input  logic                      pop,
	output head_t                     head
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	vtx_t              q_mem [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	vtx_t              item;

	assign in_ready  = (cnt_q != QCNT_W'(QDEPTH)) && !hold;
	assign push      = in_valid && in_ready;
	assign item.dx   = {local_x[COORD_W-1], local_x} - {pivot_x[COORD_W-1], pivot_x};
	assign item.dy   = {local_y[COORD_W-1], local_y} - {pivot_y[COORD_W-1], pivot_y};
	assign item.last = final_vertex;

	assign head.valid = (cnt_q != '0);
	assign head.vtx   = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= item;
		end
	end

endmodule

/* rtl/core/prtc_div.sv */
`timescale 1ns / 1ps

module prtc_div import prtc_pkg::*; #(
	parameter int SUM_W = 38,
	parameter int CNT_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SUM_W-1:0]   num_x,
	input  logic signed [SUM_W-1:0]   num_y,
	input  logic [CNT_W-1:0]          den,
	output logic                      done,
	output logic signed [COORD_W-1:0] quo_x,
	output logic signed [COORD_W-1:0] quo_y
);

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  mag_x_q, mag_y_q;
	logic [CNT_W-1:0]  rem_x_q, rem_y_q, den_q;
	logic              neg_x_q, neg_y_q, zero_q;
	logic [CNT_W:0]    trial_x, trial_y, diff_x, diff_y;
	logic              ge_x, ge_y;

	assign trial_x = {rem_x_q, mag_x_q[SUM_W-1]};
	assign trial_y = {rem_y_q, mag_y_q[SUM_W-1]};
	assign diff_x  = trial_x - {1'b0, den_q};
	assign diff_y  = trial_y - {1'b0, den_q};
	assign ge_x    = (trial_x >= {1'b0, den_q});
	assign ge_y    = (trial_y >= {1'b0, den_q});

	assign done  = done_q;
	assign quo_x = zero_q ? '0 : (neg_x_q ? -mag_x_q[COORD_W-1:0] : mag_x_q[COORD_W-1:0]);
	assign quo_y = zero_q ? '0 : (neg_y_q ? -mag_y_q[COORD_W-1:0] : mag_y_q[COORD_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			busy_q <= start || (busy_q && (step_q != '0));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_x_q <= num_x[SUM_W-1] ? $unsigned(-num_x) : $unsigned(num_x);
			mag_y_q <= num_y[SUM_W-1] ? $unsigned(-num_y) : $unsigned(num_y);
			neg_x_q <= num_x[SUM_W-1];
			neg_y_q <= num_y[SUM_W-1];
			rem_x_q <= '0;
			rem_y_q <= '0;
			den_q   <= den;
			zero_q  <= (den == '0);
			step_q  <= STEP_W'(SUM_W - 1);
		end else if (busy_q) begin
			mag_x_q <= {mag_x_q[SUM_W-2:0], ge_x};
			mag_y_q <= {mag_y_q[SUM_W-2:0], ge_y};
			rem_x_q <= ge_x ? diff_x[CNT_W-1:0] : trial_x[CNT_W-1:0];
			rem_y_q <= ge_y ? diff_y[CNT_W-1:0] : trial_y[CNT_W-1:0];
			step_q  <= step_q - 1'b1;
		end
	end

endmodule

/* rtl/core/prtc_back.sv */
`timescale 1ns / 1ps

module prtc_back import prtc_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  head_t                     head,
	output logic                      pop,
	input  logic signed [TRIG_W-1:0]  cos_value,
	input  logic signed [TRIG_W-1:0]  sin_value,
	input  logic signed [BASE_W-1:0]  base_x,
	input  logic signed [BASE_W-1:0]  base_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] world_x,
	output logic signed [COORD_W-1:0] world_y,
	output logic signed [COORD_W-1:0] centroid_x,
	output logic signed [COORD_W-1:0] centroid_y,
	output logic                      centroid_valid,
	output logic                      saturated
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int SUM_W = COORD_W + $clog2(MAX_VERTICES);

	logic                      en, retire, div_start, div_done;
	logic                      v_s1, v_s2, last_s1, last_s2;
	logic signed [PROD_W-1:0]  m_xc, m_ys, m_yc, m_xs;
	logic signed [PROD_W-1:0]  xc_s1, ys_s1, yc_s1, xs_s1;
	logic [PROD_W:0]           acc_x, acc_y;
	logic signed [ROT_W-1:0]   rx_s2, ry_s2;
	logic signed [WORLD_W-1:0] wx, wy;
	logic                      clip_x, clip_y;
	logic signed [COORD_W-1:0] sat_x, sat_y;
	logic signed [SUM_W-1:0]   sum_x_q, sum_y_q, sum_x_nx, sum_y_nx;
	logic [CNT_W-1:0]          cnt_q, cnt_nx;
	logic                      room;
	logic                      wait_q, out_valid_q;
	logic signed [COORD_W-1:0] world_x_q, world_y_q, centroid_x_q, centroid_y_q;
	logic signed [COORD_W-1:0] quo_x, quo_y;
	logic                      centroid_valid_q, saturated_q;

	assign en        = !wait_q && (!out_valid_q || out_ready);
	assign pop       = en && head.valid;
	assign retire    = en && v_s2;
	assign div_start = retire && last_s2;

	assign m_xc = $signed(head.vtx.dx) * cos_value;
	assign m_ys = $signed(head.vtx.dy) * sin_value;
	assign m_yc = $signed(head.vtx.dy) * cos_value;
	assign m_xs = $signed(head.vtx.dx) * sin_value;

	assign acc_x = {xc_s1[PROD_W-1], xc_s1} - {ys_s1[PROD_W-1], ys_s1} + (PROD_W + 1)'(32768);
	assign acc_y = {yc_s1[PROD_W-1], yc_s1} + {xs_s1[PROD_W-1], xs_s1} + (PROD_W + 1)'(32768);

	assign wx = {rx_s2[ROT_W-1], rx_s2}
		+ {{(WORLD_W - BASE_W){base_x[BASE_W-1]}}, base_x};
	assign wy = {ry_s2[ROT_W-1], ry_s2}
		+ {{(WORLD_W - BASE_W){base_y[BASE_W-1]}}, base_y};

	assign clip_x = !((&wx[WORLD_W-1:COORD_W-1]) || !(|wx[WORLD_W-1:COORD_W-1]));
	assign clip_y = !((&wy[WORLD_W-1:COORD_W-1]) || !(|wy[WORLD_W-1:COORD_W-1]));
	assign sat_x  = clip_x ? (wx[WORLD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : wx[COORD_W-1:0];
	assign sat_y  = clip_y ? (wy[WORLD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : wy[COORD_W-1:0];

	assign room     = (cnt_q < CNT_W'(MAX_VERTICES));
	assign sum_x_nx = room ? sum_x_q + SUM_W'(sat_x) : sum_x_q;
	assign sum_y_nx = room ? sum_y_q + SUM_W'(sat_y) : sum_y_q;
	assign cnt_nx   = room ? cnt_q + 1'b1 : cnt_q;

	assign out_valid      = out_valid_q;
	assign world_x        = world_x_q;
	assign world_y        = world_y_q;
	assign centroid_x     = centroid_x_q;
	assign centroid_y     = centroid_y_q;
	assign centroid_valid = centroid_valid_q;
	assign saturated      = saturated_q;

	prtc_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_x  (sum_x_nx),
		.num_y  (sum_y_nx),
		.den    (cnt_nx),
		.done   (div_done),
		.quo_x  (quo_x),
		.quo_y  (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			cnt_q       <= '0;
		end else begin
			if (en) begin
				v_s1 <= head.valid;
				v_s2 <= v_s1;
			end
			if (retire) begin
				if (last_s2) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					cnt_q   <= '0;
				end else begin
					sum_x_q <= sum_x_nx;
					sum_y_q <= sum_y_nx;
					cnt_q   <= cnt_nx;
				end
			end
			if (div_done) begin
				wait_q <= 1'b0;
			end else if (div_start) begin
				wait_q <= 1'b1;
			end
			priority if (div_done) begin
				out_valid_q <= 1'b1;
			end else if (retire) begin
				out_valid_q <= !last_s2;
			end else begin
				out_valid_q <= out_valid_q && !out_ready;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= head.vtx.last;
			xc_s1   <= m_xc;
			ys_s1   <= m_ys;
			yc_s1   <= m_yc;
			xs_s1   <= m_xs;
			last_s2 <= last_s1;
			rx_s2   <= acc_x[PROD_W:16];
			ry_s2   <= acc_y[PROD_W:16];
		end
		if (retire) begin
			world_x_q        <= sat_x;
			world_y_q        <= sat_y;
			saturated_q      <= clip_x || clip_y;
			centroid_valid_q <= last_s2;
			centroid_x_q     <= '0;
			centroid_y_q     <= '0;
		end
		if (div_done) begin
			centroid_x_q <= quo_x;
			centroid_y_q <= quo_y;
		end
	end

endmodule

/* rtl/core/prtc_chk.sv */
`timescale 1ns / 1ps

module prtc_chk import prtc_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [CFG_IDX_W-1:0]      cfg_index,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [COORD_W-1:0] world_x,
	input logic signed [COORD_W-1:0] world_y,
	input logic signed [COORD_W-1:0] centroid_x,
	input logic signed [COORD_W-1:0] centroid_y,
	input logic                      centroid_valid,
	input logic                      saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(world_x) && $stable(world_y)
			&& $stable(centroid_valid))
		else $error("result item changed while stalled");

	a_centroid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !centroid_valid |-> centroid_x == 0 && centroid_y == 0)
		else $error("centroid fields set on an ordinary vertex");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> world_x == 32'sh7fff_ffff || world_x == 32'sh8000_0000
			|| world_y == 32'sh7fff_ffff || world_y == 32'sh8000_0000)
		else $error("saturated flag without a clipped coordinate");

	a_angle_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == CFG_ANGLE |=> !in_ready)
		else $error("input taken while sine and cosine are recomputed");

endmodule

bind polygon_rotate_translate_centroid prtc_chk u_prtc_chk (.*);
